// ===== src/bps_pkg.sv =====
`default_nettype none
package bps_pkg;

  localparam int PW_W    = 16;
  localparam int FREQ_W  = 16;
  localparam int SEL_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int ACT_W   = 18;
  localparam int ADV_W   = 3;

  localparam logic [ADV_W-1:0] MAX_ADVANCE = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY   = 1'd1;

  localparam logic [PW_W-1:0]   PULSE_WIDTH_RESET = 16'd2500;
  localparam logic [FREQ_W-1:0] FREQUENCY_RESET   = 16'd40;

  localparam logic [SEL_W-1:0] SEL_A = 3'd0;
  localparam logic [SEL_W-1:0] SEL_B = 3'd2;

  typedef struct packed {
    logic [PW_W-1:0]   pulse_width;
    logic [FREQ_W-1:0] frequency;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/biphasic_pulse_sequencer.sv =====
`default_nettype none
// channel  dir  handshake           payload
// in       in   in_valid/in_ready   stim_enable
// out      out  out_valid/out_ready mux_on mux1_select mux2_select in_cycle
// cfg      in   cfg_we              cfg_index cfg_data
//
// Disabled tick: the result is registered straight from idle on accept. Enabled tick:
// S_LOOP advances phases (at most MAX_ADVANCE) and then registers the result; the
// restoring period divider runs in S_DIV each time a cycle starts with nonzero frequency.
// One transaction at a time; in_ready returns once the result register is taken.
// Synchronous reset clears the sequencer, phase state and config to defaults.
module biphasic_pulse_sequencer #(
  parameter int TICKS_PER_SECOND = 1000000,
  parameter int INTERPHASE_TICKS = 250
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           stim_enable,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                mux_on,
  output logic [bps_pkg::SEL_W-1:0]           mux1_select,
  output logic [bps_pkg::SEL_W-1:0]           mux2_select,
  output logic                                in_cycle,
  input  wire logic                           cfg_we,
  input  wire logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int QW    = $clog2(TICKS_PER_SECOND + 1);
  localparam int CW    = (QW > 16) ? QW : 16;
  localparam int CNT_W = $clog2(QW);
  localparam int SW0   = (QW > bps_pkg::ACT_W) ? QW : bps_pkg::ACT_W;
  localparam int SW    = (SW0 > bps_pkg::FREQ_W + 1) ? SW0 : bps_pkg::FREQ_W + 1;
  localparam logic [QW-1:0] TPS_VEC = QW'(TICKS_PER_SECOND);

  typedef enum logic [2:0] {PH_IDLE, PH_ONE, PH_GAP, PH_TWO, PH_REST} phase_t;
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_LOOP} state_t;

  bps_pkg::cfg_t cfg;

  bps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  state_t                      state;
  phase_t                      phase;
  logic [CW-1:0]               tick;
  logic [QW-1:0]               period;
  logic [bps_pkg::PW_W-1:0]    pw_held;
  logic [bps_pkg::SEL_W-1:0]   mux1_latched;
  logic [bps_pkg::SEL_W-1:0]   mux2_latched;
  logic [bps_pkg::ADV_W-1:0]   guard;
  logic [bps_pkg::FREQ_W-1:0]  div_rem;
  logic [QW-1:0]               div_quo;
  logic [CNT_W-1:0]            div_cnt;

  logic                        div_bit;
  logic [bps_pkg::FREQ_W:0]    shift_a;
  logic [SW-1:0]               sub_a;
  logic [SW-1:0]               sub_b;
  logic [SW:0]                 diff_full;
  logic                        borrow;
  logic [bps_pkg::FREQ_W-1:0]  rem_next;
  logic [QW-1:0]               quo_next;
  logic [bps_pkg::ACT_W-1:0]   active;
  logic [SW-1:0]               rest_raw;
  logic [CW-1:0]               rest_ticks;
  logic                        accept;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign accept   = in_valid && in_ready;

  // shared subtractor: divider step, or period minus active time
  always_comb begin
    div_bit   = TPS_VEC[div_cnt];
    shift_a   = {div_rem, div_bit};
    active    = bps_pkg::ACT_W'({pw_held, 1'b0}) + bps_pkg::ACT_W'(INTERPHASE_TICKS);
    sub_a     = (state == S_DIV) ? SW'(shift_a) : SW'(period);
    sub_b     = (state == S_DIV) ? SW'(cfg.frequency) : SW'(active);
    diff_full = {1'b0, sub_a} - {1'b0, sub_b};
    borrow    = diff_full[SW];
    rem_next  = borrow ? shift_a[bps_pkg::FREQ_W-1:0] : diff_full[bps_pkg::FREQ_W-1:0];
    quo_next  = {div_quo[QW-2:0], !borrow};
    rest_raw  = borrow ? '0 : diff_full[SW-1:0];
    rest_ticks = CW'(rest_raw);
    if (active == '0 && rest_raw == '0) begin
      rest_ticks = CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_IDLE;
      tick         <= '0;
      period       <= '0;
      pw_held      <= '0;
      mux1_latched <= '0;
      mux2_latched <= '0;
      guard        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            guard <= '0;
            if (!stim_enable) begin
              phase       <= PH_IDLE;
              tick        <= '0;
              mux_on      <= 1'b0;
              mux1_select <= mux1_latched;
              mux2_select <= mux2_latched;
              in_cycle    <= 1'b0;
              out_valid   <= 1'b1;
            end else if (phase == PH_IDLE) begin
              pw_held      <= cfg.pulse_width;
              phase        <= PH_ONE;
              tick         <= CW'(cfg.pulse_width);
              mux1_latched <= bps_pkg::SEL_A;
              mux2_latched <= bps_pkg::SEL_B;
              div_rem      <= '0;
              div_quo      <= '0;
              div_cnt      <= CNT_W'(QW - 1);
              if (cfg.frequency == '0) begin
                period <= '0;
                state  <= S_LOOP;
              end else begin
                state  <= S_DIV;
              end
            end else begin
              state <= S_LOOP;
            end
          end
        end
        S_DIV: begin
          div_rem <= rem_next;
          div_quo <= quo_next;
          if (div_cnt == '0) begin
            period <= quo_next;
            state  <= S_LOOP;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        S_LOOP: begin
          if (tick == '0 && guard < bps_pkg::MAX_ADVANCE) begin
            guard <= guard + 1'b1;
            case (phase)
              PH_ONE: begin
                phase <= PH_GAP;
                tick  <= CW'(INTERPHASE_TICKS);
              end
              PH_GAP: begin
                phase        <= PH_TWO;
                tick         <= CW'(pw_held);
                mux1_latched <= bps_pkg::SEL_B;
                mux2_latched <= bps_pkg::SEL_A;
              end
              PH_TWO: begin
                phase <= PH_REST;
                tick  <= rest_ticks;
              end
              default: begin
                pw_held      <= cfg.pulse_width;
                phase        <= PH_ONE;
                tick         <= CW'(cfg.pulse_width);
                mux1_latched <= bps_pkg::SEL_A;
                mux2_latched <= bps_pkg::SEL_B;
                div_rem      <= '0;
                div_quo      <= '0;
                div_cnt      <= CNT_W'(QW - 1);
                if (cfg.frequency == '0) begin
                  period <= '0;
                end else begin
                  state  <= S_DIV;
                end
              end
            endcase
          end else begin
            mux_on      <= (phase == PH_ONE) || (phase == PH_TWO);
            mux1_select <= mux1_latched;
            mux2_select <= mux2_latched;
            in_cycle    <= 1'b1;
            out_valid   <= 1'b1;
            guard       <= '0;
            state       <= S_IDLE;
            if (tick != '0) begin
              tick <= tick - 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/bps_cfg.sv =====
`default_nettype none
module bps_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bps_pkg::CFG_DATA_W-1:0] cfg_data,
  output bps_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_width <= bps_pkg::PULSE_WIDTH_RESET;
      cfg.frequency   <= bps_pkg::FREQUENCY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bps_pkg::CFG_PULSE_WIDTH: cfg.pulse_width <= cfg_data[bps_pkg::PW_W-1:0];
        bps_pkg::CFG_FREQUENCY:   cfg.frequency   <= cfg_data[bps_pkg::FREQ_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== test/biphasic_pulse_sequencer_test.sv =====
`timescale 1ns / 1ps
module biphasic_pulse_sequencer_test;

  localparam int TICK_RATE   = 1000000;
  localparam int GAP_TICKS   = 250;
  localparam int TOTAL_ITEMS = 1450;
  localparam int TAIL_START  = TOTAL_ITEMS - 150;
  localparam int PRESSURE_AT = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_TAIL  = 40;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_DRIVE_A, SEQ_GAP, SEQ_DRIVE_B, SEQ_REST
  } seq_phase_t;

  typedef struct packed {
    logic                      on;
    logic [bps_pkg::SEL_W-1:0] first_sel;
    logic [bps_pkg::SEL_W-1:0] second_sel;
    logic                      active;
  } mux_state_t;

  typedef struct packed {
    logic                       load;
    logic [bps_pkg::PW_W-1:0]   width;
    logic [bps_pkg::FREQ_W-1:0] freq;
    logic                       en;
    logic                       typed;
    mux_state_t                 want;
  } dir_row_t;

  // typed rows: disable, cycle start and zero-width entry are obvious
  localparam dir_row_t DIRECTED [20] = '{
    '{1'b0, 16'd0, 16'd0, 1'b0, 1'b1, '{1'b0, bps_pkg::SEL_A, bps_pkg::SEL_A, 1'b0}},
    '{1'b0, 16'd0, 16'd0, 1'b1, 1'b1, '{1'b1, bps_pkg::SEL_A, bps_pkg::SEL_B, 1'b1}},
    '{1'b0, 16'd0, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, 16'd0, 16'd0, 1'b0, 1'b1, '{1'b0, bps_pkg::SEL_A, bps_pkg::SEL_B, 1'b0}},
    '{1'b1, 16'd0, 16'd0, 1'b1, 1'b1, '{1'b0, bps_pkg::SEL_A, bps_pkg::SEL_B, 1'b1}},
    '{1'b0, 16'd0, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, 16'd0, 16'd0, 1'b0, 1'b1, '{1'b0, bps_pkg::SEL_A, bps_pkg::SEL_B, 1'b0}},
    '{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
      '{1'b1, bps_pkg::SEL_A, bps_pkg::SEL_B, 1'b1}},
    '{1'b0, 16'd0, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, 16'd0, 16'd0, 1'b0, 1'b1, '{1'b0, bps_pkg::SEL_A, bps_pkg::SEL_B, 1'b0}},
    '{1'b1, 16'd1, 16'd1, 1'b1, 1'b1, '{1'b1, bps_pkg::SEL_A, bps_pkg::SEL_B, 1'b1}},
    '{1'b0, 16'd0, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, 16'd0, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, 16'd0, 16'd0, 1'b0, 1'b1, '{1'b0, bps_pkg::SEL_A, bps_pkg::SEL_B, 1'b0}},
    '{1'b1, 16'd0, 16'd4000, 1'b1, 1'b1,
      '{1'b0, bps_pkg::SEL_A, bps_pkg::SEL_B, 1'b1}},
    '{1'b0, 16'd0, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, 16'd0, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, 16'd0, 16'd0, 1'b1, 1'b0, '0},
    '{1'b0, 16'd0, 16'd0, 1'b0, 1'b1, '{1'b0, bps_pkg::SEL_A, bps_pkg::SEL_B, 1'b0}},
    '{1'b1, 16'hAAAA, 16'h5555, 1'b1, 1'b1,
      '{1'b1, bps_pkg::SEL_A, bps_pkg::SEL_B, 1'b1}}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           stim_enable = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           mux_on;
  logic [bps_pkg::SEL_W-1:0]      mux1_select;
  logic [bps_pkg::SEL_W-1:0]      mux2_select;
  logic                           in_cycle;
  logic                           cfg_we = 1'b0;
  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index = bps_pkg::CFG_PULSE_WIDTH;
  logic [bps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  seq_phase_t                 phase = SEQ_IDLE;
  logic [19:0]                ticks_left = '0;
  logic [19:0]                period = '0;
  logic [bps_pkg::SEL_W-1:0]  sel1 = '0;
  logic [bps_pkg::SEL_W-1:0]  sel2 = '0;
  logic [bps_pkg::PW_W-1:0]   held_width = '0;
  logic [bps_pkg::PW_W-1:0]   set_width = bps_pkg::PULSE_WIDTH_RESET;
  logic [bps_pkg::FREQ_W-1:0] set_freq = bps_pkg::FREQUENCY_RESET;

  mux_state_t mux_states_due[$];
  int         sent_items = 0;
  int         mismatches = 0;
  bit         quiet = 1'b0;

  biphasic_pulse_sequencer #(
    .TICKS_PER_SECOND(TICK_RATE),
    .INTERPHASE_TICKS(GAP_TICKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stim_enable(stim_enable),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .mux_on(mux_on),
    .mux1_select(mux1_select),
    .mux2_select(mux2_select),
    .in_cycle(in_cycle),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic begin_pulse_cycle();
    held_width = set_width;
    period = (set_freq != 0) ? 20'(TICK_RATE / int'(set_freq)) : 20'd0;
    phase = SEQ_DRIVE_A;
    ticks_left = 20'(held_width);
    sel1 = bps_pkg::SEL_A;
    sel2 = bps_pkg::SEL_B;
  endtask

  task automatic advance_phase();
    int active_ticks;
    int rest_ticks;
    case (phase)
      SEQ_DRIVE_A: begin
        phase = SEQ_GAP;
        ticks_left = 20'(GAP_TICKS);
      end
      SEQ_GAP: begin
        phase = SEQ_DRIVE_B;
        ticks_left = 20'(held_width);
        sel1 = bps_pkg::SEL_B;
        sel2 = bps_pkg::SEL_A;
      end
      SEQ_DRIVE_B: begin
        active_ticks = 2 * int'(held_width) + GAP_TICKS;
        rest_ticks = (int'(period) > active_ticks) ? int'(period) - active_ticks : 0;
        if (active_ticks == 0 && rest_ticks == 0) rest_ticks = 1;
        phase = SEQ_REST;
        ticks_left = 20'(rest_ticks);
      end
      default: begin_pulse_cycle();
    endcase
  endtask

  task automatic next_mux_state(input logic en, output mux_state_t r);
    int guard;
    if (!en) begin
      phase = SEQ_IDLE;
      ticks_left = '0;
      r = '{1'b0, sel1, sel2, 1'b0};
    end else begin
      if (phase == SEQ_IDLE) begin_pulse_cycle();
      for (guard = 0; guard < 6 && ticks_left == 0; guard++) advance_phase();
      r = '{(phase == SEQ_DRIVE_A || phase == SEQ_DRIVE_B), sel1, sel2, 1'b1};
      if (ticks_left != 0) ticks_left = ticks_left - 20'd1;
    end
  endtask

  task automatic offer_tick(input logic en, input logic typed, input mux_state_t want);
    mux_state_t predicted;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    stim_enable <= en;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    next_mux_state(en, predicted);
    mux_states_due.push_back(typed ? want : predicted);
    sent_items++;
    quiet = (sent_items >= TAIL_START);
  endtask

  // only while idle: every result drained first
  task automatic load_settings(input logic [bps_pkg::PW_W-1:0] width,
                               input logic [bps_pkg::FREQ_W-1:0] freq);
    in_valid <= 1'b0;
    while (mux_states_due.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= bps_pkg::CFG_PULSE_WIDTH;
    cfg_data <= width;
    @(posedge clk);
    cfg_index <= bps_pkg::CFG_FREQUENCY;
    cfg_data <= freq;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_width = width;
    set_freq = freq;
  endtask

  initial begin
    logic [bps_pkg::PW_W-1:0]   width;
    logic [bps_pkg::FREQ_W-1:0] freq;
    int                         seg_len;
    bit                         noisy;
    bit                         en;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].load) load_settings(DIRECTED[i].width, DIRECTED[i].freq);
      offer_tick(DIRECTED[i].en, DIRECTED[i].typed, DIRECTED[i].want);
    end
    while (sent_items < TOTAL_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0: begin
            width = bps_pkg::PW_W'($urandom_range(0, 3));
            freq = '0;
          end
          1: begin
            width = bps_pkg::PW_W'($urandom_range(0, 40));
            freq = bps_pkg::FREQ_W'($urandom_range(2500, 4000));
          end
          2: begin
            width = bps_pkg::PW_W'($urandom_range(0, 30));
            freq = 16'hFFFF;
          end
          3: begin
            width = bps_pkg::PW_W'($urandom_range(0, 65535));
            freq = bps_pkg::FREQ_W'($urandom_range(0, 65535));
          end
          4: begin
            width = bps_pkg::PW_W'($urandom_range(0, 20));
            freq = bps_pkg::FREQ_W'($urandom_range(1, 65535));
          end
          default: begin
            width = bps_pkg::PW_W'($urandom_range(0, 10));
            freq = bps_pkg::FREQ_W'($urandom_range(3000, 3900));
          end
        endcase
        load_settings(width, freq);
      end
      seg_len = $urandom_range(120, 400);
      noisy = ($urandom_range(0, 7) == 0);
      repeat (seg_len) begin
        if (sent_items < TOTAL_ITEMS) begin
          en = noisy ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 149) != 0);
          offer_tick(en, 1'b0, '0);
        end
      end
    end
    in_valid <= 1'b0;
    while (mux_states_due.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    mux_state_t want;
    int         hold_left;
    bit         pressed;
    hold_left = 0;
    pressed = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (mux_states_due.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          want = mux_states_due.pop_front();
          if (mux_on !== want.on)
            report_mismatch($sformatf("mux_on %0b want %0b", mux_on, want.on));
          if (mux1_select !== want.first_sel)
            report_mismatch($sformatf("mux1_select %0d want %0d",
                                      mux1_select, want.first_sel));
          if (mux2_select !== want.second_sel)
            report_mismatch($sformatf("mux2_select %0d want %0d",
                                      mux2_select, want.second_sel));
          if (in_cycle !== want.active)
            report_mismatch($sformatf("in_cycle %0b want %0b", in_cycle, want.active));
        end
      end
      if (!pressed && sent_items >= PRESSURE_AT) begin
        pressed = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
